### rtl/adcmavg_pkg.sv
// Shared widths and scaling constants for the ADC moving-average temperature block.
`timescale 1ns / 1ps
package adcmavg_pkg;

  localparam int unsigned SAMPLE_W         = 12;
  localparam int unsigned TEMP_W           = 16;
  localparam int unsigned COUNT_W          = 5;
  localparam int unsigned IN_TDATA_W       = 16;
  localparam int unsigned OUT_TDATA_W      = 24;
  localparam int unsigned WINDOW_SIZE_DEF  = 16;
  localparam int unsigned FULL_SCALE_CODE  = 4095;
  localparam int unsigned FULL_SCALE_CENTI = 33000;

endpackage

### rtl/adcmavg_ring.sv
// Sample ring with running sum and fill count.
`timescale 1ns / 1ps
module adcmavg_ring #(
  parameter int unsigned WINDOW_SIZE = adcmavg_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned SLOT_W      = $clog2(WINDOW_SIZE),
  parameter int unsigned CNT_W       = $clog2(WINDOW_SIZE + 1),
  parameter int unsigned SUM_W       = adcmavg_pkg::SAMPLE_W + $clog2(WINDOW_SIZE)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [adcmavg_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SUM_W-1:0]                  sum_o,
  output logic [CNT_W-1:0]                  count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_HOLD
  } state_e;

  state_e                           state_q;
  logic [SLOT_W-1:0]                slot_q;
  logic [CNT_W-1:0]                 count_q;
  logic [SUM_W-1:0]                 sum_q;
  logic [adcmavg_pkg::SAMPLE_W-1:0] sample_q;
  logic [adcmavg_pkg::SAMPLE_W-1:0] rd_q;
  logic [adcmavg_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_SIZE];

  logic                             full;
  logic [SUM_W-1:0]                 sum_d;
  logic [SUM_W-1:0]                 drop_val;

  assign full     = (count_q == CNT_W'(WINDOW_SIZE));
  assign drop_val = full ? SUM_W'(rd_q) : '0;
  assign sum_d    = sum_q - drop_val + SUM_W'(sample_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_HOLD);
  assign sum_o       = sum_q;
  assign count_o     = count_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      ring_mem[slot_q] <= sample_q;
    end
    rd_q <= ring_mem[slot_q];
    if (in_valid_i && state_q == S_IDLE) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          sum_q <= sum_d;
          if (slot_q == SLOT_W'(WINDOW_SIZE - 1)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + SLOT_W'(1);
          end
          if (!full) begin
            count_q <= count_q + CNT_W'(1);
          end
          state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/adcmavg_div.sv
// Scaling multiply and bit-serial restoring divide, one quotient bit per cycle.
`timescale 1ns / 1ps
module adcmavg_div #(
  parameter int unsigned WINDOW_SIZE = adcmavg_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned CNT_W       = $clog2(WINDOW_SIZE + 1),
  parameter int unsigned SUM_W       = adcmavg_pkg::SAMPLE_W + $clog2(WINDOW_SIZE)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SUM_W-1:0]                 sum_i,
  input  logic [CNT_W-1:0]                 count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adcmavg_pkg::TEMP_W-1:0]   temp_o,
  output logic [adcmavg_pkg::COUNT_W-1:0]  count_o
);

  localparam int unsigned Q_W    = adcmavg_pkg::TEMP_W;
  localparam int unsigned NUM_W  = SUM_W + Q_W;
  localparam int unsigned DEN_W  = CNT_W + adcmavg_pkg::SAMPLE_W;
  localparam int unsigned R_W    = DEN_W + 1;
  localparam int unsigned STEP_W = $clog2(Q_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    den_q;
  logic [R_W-1:0]      rem_q;
  logic [Q_W-1:0]      quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [STEP_W-1:0]   step_q;

  logic [R_W-1:0]      trial;
  logic                fits;
  logic [CNT_W+4:0]    cnt_ext;

  assign trial   = {rem_q[DEN_W-1:0], quo_q[Q_W-1]};
  assign fits    = (trial >= {1'b0, den_q});
  assign cnt_ext = {5'b0, cnt_q};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign temp_o      = quo_q;
  assign count_o     = cnt_ext[adcmavg_pkg::COUNT_W-1:0];

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        num_q <= NUM_W'(sum_i) * NUM_W'(adcmavg_pkg::FULL_SCALE_CENTI);
        den_q <= DEN_W'(count_i) * DEN_W'(adcmavg_pkg::FULL_SCALE_CODE);
        cnt_q <= count_i;
      end
      S_LOAD: begin
        rem_q <= R_W'(num_q[NUM_W-1:Q_W]);
        quo_q <= num_q[Q_W-1:0];
      end
      S_DIV: begin
        rem_q <= fits ? (trial - R_W'(den_q)) : trial;
        quo_q <= {quo_q[Q_W-2:0], fits};
      end
      S_DONE: begin
        quo_q <= quo_q;
      end
      default: begin
        quo_q <= quo_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(Q_W - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/adc_moving_average_temperature_core.sv
// Moving-average ADC temperature filter: top level with output register.
//
// Usage: each word on the slave stream carries one 12-bit converter code.
// The code enters a ring of WINDOW_SIZE samples with a running sum; the
// result word gives the averaged temperature in hundredths of a degree,
// sum*33000/(4095*count) truncated, and the number of samples covered.
// Until the ring first wraps the count is the number of samples so far.
// From input accept to the result in the output register the word passes:
// the sum update (the ring is read at the accept edge), the handoff with
// the scaling multiply, the load, sixteen divide steps at one quotient
// bit each and the move into the output register. The bit-serial divider
// sets the throughput: it takes no new sum until its result has left. The
// output register frees the divider, so the next word is accepted while a
// result waits on a stalled master side; the divider then holds its finished
// result until the register drains.
// Reset clears the sum, fill count, write slot and all valid flags; ring
// contents are not cleared since an entry is read only after being written.
`timescale 1ns / 1ps
module adc_moving_average_temperature_core #(
  parameter int unsigned WINDOW_SIZE = adcmavg_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [11:0] adc_sample, [15:12] zero
  input  logic [adcmavg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [15:0] smoothed_temp_centi, [20:16] samples_averaged, [23:21] zero
  output logic [adcmavg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SUM_W  = adcmavg_pkg::SAMPLE_W + $clog2(WINDOW_SIZE);
  localparam int unsigned SLOT_W = $clog2(WINDOW_SIZE);
  localparam int unsigned RES_W  = adcmavg_pkg::TEMP_W + adcmavg_pkg::COUNT_W;

  logic                             ring_valid;
  logic                             ring_ready;
  logic [SUM_W-1:0]                 ring_sum;
  logic [CNT_W-1:0]                 ring_count;
  logic                             div_valid;
  logic                             div_take;
  logic [adcmavg_pkg::TEMP_W-1:0]   div_temp;
  logic [adcmavg_pkg::COUNT_W-1:0]  div_count;

  logic                             out_valid_q;
  logic [RES_W-1:0]                 out_data_q;

  adcmavg_ring #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SLOT_W      (SLOT_W),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[adcmavg_pkg::SAMPLE_W-1:0]),
    .out_valid_o (ring_valid),
    .out_ready_i (ring_ready),
    .sum_o       (ring_sum),
    .count_o     (ring_count)
  );

  adcmavg_div #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ring_valid),
    .in_ready_o  (ring_ready),
    .sum_i       (ring_sum),
    .count_i     (ring_count),
    .out_valid_o (div_valid),
    .out_ready_i (div_take),
    .temp_o      (div_temp),
    .count_o     (div_count)
  );

  assign div_take = div_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      out_data_q <= {div_count, div_temp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(adcmavg_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_data_q};

endmodule

### sim/adc_moving_average_temperature_core_tb.sv
// Self-checking stream testbench for the ADC moving-average temperature core.
`timescale 1ns / 1ps
module adc_moving_average_temperature_core_tb;

  localparam int unsigned SAMPLE_W         = adcmavg_pkg::SAMPLE_W;
  localparam int unsigned TEMP_W           = adcmavg_pkg::TEMP_W;
  localparam int unsigned COUNT_W          = adcmavg_pkg::COUNT_W;
  localparam int unsigned IN_TDATA_W       = adcmavg_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W      = adcmavg_pkg::OUT_TDATA_W;
  localparam int unsigned FULL_SCALE_CODE  = adcmavg_pkg::FULL_SCALE_CODE;
  localparam int unsigned FULL_SCALE_CENTI = adcmavg_pkg::FULL_SCALE_CENTI;

  localparam int unsigned WINDOW      = adcmavg_pkg::WINDOW_SIZE_DEF;
  localparam int unsigned RAND_WORDS  = 900;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [SAMPLE_W-1:0] CODE_MAX = SAMPLE_W'(FULL_SCALE_CODE);

  typedef struct {
    logic [IN_TDATA_W-1:0] word;
    bit                    drain_first;
  } sample_item_t;

  typedef struct {
    logic [TEMP_W-1:0]  temp_centi;
    logic [COUNT_W-1:0] count;
  } reading_t;

  typedef enum {GEN_UNIFORM, GEN_EXTREME, GEN_TRACK, GEN_RUN, GEN_WIDE} gen_kind_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sample_item_t pending_samples[$];
  reading_t     expected_readings[$];

  logic [SAMPLE_W-1:0] ring_model[WINDOW];
  int unsigned         slot_model    = 0;
  bit                  wrapped_model = 1'b0;
  int unsigned         sum_model     = 0;

  int unsigned send_gap     = 0;
  int unsigned send_burst   = 0;
  int unsigned recv_gap     = 0;
  int unsigned recv_burst   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned samples_sent = 0;
  int unsigned wide_words   = 0;
  int unsigned drain_pauses = 0;
  int unsigned readings_ok  = 0;
  int unsigned readings_all = 0;
  int unsigned full_scale   = 0;
  int unsigned zero_temp    = 0;
  int unsigned partial_win  = 0;
  int unsigned errors       = 0;

  adc_moving_average_temperature_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  task automatic predict_reading(input logic [IN_TDATA_W-1:0] word);
    logic [SAMPLE_W-1:0] code;
    int unsigned         cnt;
    longint unsigned     num;
    longint unsigned     den;
    longint unsigned     quot;
    reading_t            r;
    code = word[SAMPLE_W-1:0];
    if (wrapped_model) sum_model -= ring_model[slot_model];
    ring_model[slot_model] = code;
    sum_model += code;
    slot_model++;
    if (slot_model >= WINDOW) begin
      slot_model    = 0;
      wrapped_model = 1'b1;
    end
    cnt  = wrapped_model ? WINDOW : slot_model;
    num  = 64'(sum_model) * 64'(FULL_SCALE_CENTI);
    den  = 64'(FULL_SCALE_CODE) * 64'(cnt);
    quot = (den != 0) ? num / den : 64'd0;
    r.temp_centi = quot[TEMP_W-1:0];
    r.count      = cnt[COUNT_W-1:0];
    expected_readings.push_back(r);
  endtask

  function automatic int unsigned draw_wait(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 12'd1;
      2:       return CODE_MAX - 1;
      default: return CODE_MAX;
    endcase
  endfunction

  // Source side: present queued words, honor drain requests, insert gaps.
  always @(posedge clk_i) begin : drive_proc
    logic                  valid_n;
    logic [IN_TDATA_W-1:0] data_n;
    sample_item_t          item;
    valid_n = s_axis_tvalid;
    data_n  = s_axis_tdata;
    if (!rst_ni) begin
      valid_n = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_reading(s_axis_tdata);
        samples_sent++;
        valid_n  = 1'b0;
        data_n   = IN_TDATA_W'($urandom);
        send_gap = draw_wait(send_burst);
      end
      if (!valid_n) begin
        if (send_gap > 0) begin
          if (s_axis_tready || expected_readings.size() == 0) send_gap--;
        end else if (pending_samples.size() > 0 &&
                     (!pending_samples[0].drain_first ||
                      expected_readings.size() == 0)) begin
          item    = pending_samples.pop_front();
          valid_n = 1'b1;
          data_n  = item.word;
          if (item.drain_first) drain_pauses++;
        end
      end
    end
    s_axis_tvalid <= valid_n;
    s_axis_tdata  <= data_n;
  end

  // Sink side: check each accepted word against the oldest expected reading.
  always @(posedge clk_i) begin : watch_proc
    logic     ready_n;
    reading_t exp_r;
    reading_t got_r;
    ready_n = m_axis_tready;
    if (!rst_ni) begin
      ready_n = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.temp_centi = m_axis_tdata[TEMP_W-1:0];
        got_r.count      = m_axis_tdata[TEMP_W +: COUNT_W];
        readings_all++;
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] unexpected reading: temp=%0d count=%0d",
                     $realtime, got_r.temp_centi, got_r.count);
        end else begin
          exp_r = expected_readings.pop_front();
          if (got_r.temp_centi !== exp_r.temp_centi || got_r.count !== exp_r.count) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("[%0t] reading mismatch: expected temp=%0d count=%0d, %s%0d count=%0d",
                       $realtime, exp_r.temp_centi, exp_r.count, "got temp=",
                       got_r.temp_centi, got_r.count);
          end else begin
            readings_ok++;
            if (exp_r.temp_centi == TEMP_W'(FULL_SCALE_CENTI)) full_scale++;
            if (exp_r.temp_centi == '0) zero_temp++;
            if (exp_r.count != COUNT_W'(WINDOW)) partial_win++;
          end
        end
        recv_gap = draw_wait(recv_burst);
        ready_n  = (recv_gap == 0);
      end else if (!m_axis_tready) begin
        if (recv_gap == 0) ready_n = 1'b1;
        else if (m_axis_tvalid) recv_gap--;
      end
    end
    m_axis_tready <= ready_n;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d readings outstanding",
               idle_cycles, expected_readings.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stim_proc
    sample_item_t        item;
    gen_kind_e           kind;
    int                  level;
    int                  code;
    int unsigned         run_len;
    int unsigned         produced;
    logic [SAMPLE_W-1:0] run_code;

    // Fill the window at full scale, then pull it down and probe bit patterns.
    item.drain_first = 1'b0;
    repeat (WINDOW) begin
      item.word = IN_TDATA_W'(CODE_MAX);
      pending_samples.push_back(item);
    end
    repeat (3) begin
      item.word = '0;
      pending_samples.push_back(item);
    end
    item.word = 16'h0555; pending_samples.push_back(item);
    item.word = 16'h0aaa; pending_samples.push_back(item);
    item.word = 16'hf123; pending_samples.push_back(item);
    item.word = 16'h8001; pending_samples.push_back(item);
    item.word = 16'h0001; pending_samples.push_back(item);
    item.word = 16'h0800; pending_samples.push_back(item);

    level    = 1240;
    produced = 0;
    while (produced < RAND_WORDS) begin
      kind    = gen_kind_e'($urandom_range(0, GEN_WIDE));
      run_len = 1;
      case (kind)
        GEN_UNIFORM: code = $urandom_range(0, FULL_SCALE_CODE);
        GEN_EXTREME: code = pick_extreme();
        GEN_TRACK: begin
          level = level + $urandom_range(0, 40) - 20;
          if (level < 0) level = 0;
          if (level > FULL_SCALE_CODE) level = FULL_SCALE_CODE;
          code = level + $urandom_range(0, 16) - 8;
          if (code < 0) code = 0;
          if (code > FULL_SCALE_CODE) code = FULL_SCALE_CODE;
        end
        GEN_RUN: begin
          run_code = $urandom_range(0, 1) ? pick_extreme() : SAMPLE_W'($urandom);
          code     = run_code;
          run_len  = $urandom_range(4, WINDOW + 4);
        end
        default: code = $urandom_range(0, FULL_SCALE_CODE);
      endcase
      repeat (run_len) begin
        item.word = IN_TDATA_W'(code);
        if (kind == GEN_WIDE)
          item.word[IN_TDATA_W-1:SAMPLE_W] =
            (IN_TDATA_W - SAMPLE_W)'($urandom_range(1, 15));
        item.drain_first = (produced == 0) || (produced == RAND_WORDS / 2) ||
                           ($urandom_range(0, 99) == 0);
        pending_samples.push_back(item);
        produced++;
      end
    end
    foreach (pending_samples[i])
      if (pending_samples[i].word[IN_TDATA_W-1:SAMPLE_W] != '0) wide_words++;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_samples.size() == 0 && !s_axis_tvalid);
    wait (expected_readings.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_readings.size() != 0) begin
      errors++;
      $display("%0d expected readings never arrived", expected_readings.size());
    end
    $display("run: %0d samples sent (%0d with high padding bits set), %0d readings seen",
             samples_sent, wide_words, readings_all);
    $display("run: %0d drain pauses, %0d full-scale, %0d zero, %0d partial-window readings",
             drain_pauses, full_scale, zero_temp, partial_win);
    $display("run: %0d errors", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/adcmavg_pkg.sv
rtl/adcmavg_ring.sv
rtl/adcmavg_div.sv
rtl/adc_moving_average_temperature_core.sv
sim/adc_moving_average_temperature_core_tb.sv
